// File: rtl/core/assert_macros.svh
// Assertion macros for the port-level checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is high.
`define LCC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Trigger in this cycle implies consequence in the next one.
`define LCC_ASSERT_NEXT(label, trig, cons, msg) \
  `LCC_ASSERT(label, (trig) |=> (cons), msg)

`endif

// File: rtl/core/lcc_pkg.sv
// Package: types, microcode word layout and step labels for the component-size unit.
package lcc_pkg;

  localparam int MAX_V = 1024;
  localparam int VW    = $clog2(MAX_V);
  localparam int SW    = $clog2(MAX_V) + 1;
  localparam int PC_W  = 4;

  typedef logic [VW-1:0]   vtx_t;
  typedef logic [SW-1:0]   cnt_t;
  typedef logic [PC_W-1:0] pc_t;

  // one word of the union-find store
  typedef struct packed {
    vtx_t parent;
    cnt_t sz;
  } entry_t;

  typedef enum logic [3:0] {
    C_NEVER,
    C_ALWAYS,
    C_NOT_FIRE,
    C_CMD,
    C_OOR,
    C_NOT_ROOT,
    C_SAME,
    C_OUT_BUSY,
    C_CLR_MORE
  } cond_e;

  typedef enum logic [3:0] {
    LD_NONE,
    LD_TAKE,
    LD_START,
    LD_FIND_A,
    LD_FIND_B,
    LD_BEST,
    LD_EMIT,
    LD_CLEAR
  } ld_e;

  typedef enum logic [1:0] {
    W_LINK,
    W_GROW,
    W_CLEAR
  } wsel_e;

  typedef struct packed {
    logic  accept;
    logic  mem_we;
    wsel_e wsel;
    ld_e   ld;
    cond_e cond;
    pc_t   target;
  } uword_t;

  // datapath status seen by the sequencer
  typedef struct packed {
    logic fire;
    logic cmd;
    logic oor;
    logic not_root;
    logic same;
    logic out_busy;
    logic clr_more;
  } flags_t;

  localparam pc_t ST_WAIT   = 4'd0;
  localparam pc_t ST_DISP   = 4'd1;
  localparam pc_t ST_RANGE  = 4'd2;
  localparam pc_t ST_RD_A   = 4'd3;
  localparam pc_t ST_CHK_A  = 4'd4;
  localparam pc_t ST_RD_B   = 4'd5;
  localparam pc_t ST_CHK_B  = 4'd6;
  localparam pc_t ST_LINK   = 4'd7;
  localparam pc_t ST_GROW   = 4'd8;
  localparam pc_t ST_EMIT   = 4'd9;
  localparam pc_t ST_CLEAR  = 4'd10;
  localparam pc_t ST_BACK   = 4'd11;

endpackage

// File: rtl/core/largest_connected_component_unit.sv
// Top level: union-by-size store with a microcoded sequencer for largest component size.
// Edge item: both endpoints are walked to their roots, then the smaller root is linked under
//   the larger, which grows; a shared root stops at the link step, an out-of-range edge at
//   the range check. Endpoint tree depths are at most 10 by size. Each tree level costs one
//   registered read of the store plus one check. End item: one result, then a clearing pass
//   over all 1024 store entries. Reset (synchronous, rst high): vertex_count 0, then the same
//   clearing pass, item_ready low throughout; configuration writes are taken while rst is low.
module largest_connected_component_unit import lcc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  // config
  input  logic        write_enable,
  input  logic [9:0]  write_data,
  // item in
  input  logic        item_valid,
  output logic        item_ready,
  input  logic        command,
  input  logic [9:0]  endpoint_a,
  input  logic [9:0]  endpoint_b,
  // result out
  output logic        result_valid,
  input  logic        result_ready,
  output logic [10:0] largest_size,
  output logic        bad_edge_seen
);

  // store: one word per vertex holds parent and subtree size
  entry_t mem [MAX_V];
  entry_t rd;            // registered read of mem[cur]

  uword_t uw;
  logic   jump;
  flags_t flags;

  logic [9:0] vertex_count;

  // item latch and walk registers
  logic  cmd_r;
  vtx_t  a_r;
  vtx_t  b_r;
  vtx_t  cur;            // vertex being walked toward its root
  vtx_t  ra;
  vtx_t  rb;
  cnt_t  sza;
  cnt_t  szb;

  // control state
  cnt_t  best;
  logic  bad;
  vtx_t  clr;

  logic       fire;
  logic [9:0] limit;
  logic       oor;
  vtx_t       hi_root;   // surviving root
  vtx_t       lo_root;   // root that gets linked under hi_root
  cnt_t       lo_sz;
  cnt_t       merged;
  vtx_t       waddr;
  entry_t     wdata;

  lcc_seq u_seq (
    .clk   (clk),
    .rst   (rst),
    .flags (flags),
    .uw    (uw),
    .jump  (jump)
  );

  assign item_ready = uw.accept;
  assign fire       = item_valid && uw.accept;

  // vertex limit saturates at the highest store index
  assign limit = (vertex_count > 10'(MAX_V - 1)) ? 10'(MAX_V - 1) : vertex_count;
  assign oor   = (10'(a_r) > limit) || (10'(b_r) > limit);

  // larger set wins; ties keep the first endpoint's root
  assign hi_root = (sza >= szb) ? ra : rb;
  assign lo_root = (sza >= szb) ? rb : ra;
  assign lo_sz   = (sza >= szb) ? szb : sza;
  assign merged  = sza + szb;

  always_comb begin
    flags.fire     = fire;
    flags.cmd      = cmd_r;
    flags.oor      = oor;
    flags.not_root = (rd.parent != cur);
    flags.same     = (ra == rb);
    flags.out_busy = result_valid && !result_ready;
    flags.clr_more = (clr != VW'(MAX_V - 1));
  end

  // write port: link, grow, or clear
  always_comb begin
    unique case (uw.wsel)
      W_LINK: begin
        waddr = lo_root;
        wdata = '{parent: hi_root, sz: lo_sz};
      end
      W_GROW: begin
        waddr = hi_root;
        wdata = '{parent: hi_root, sz: merged};
      end
      W_CLEAR: begin
        waddr = clr;
        wdata = '{parent: clr, sz: SW'(1)};
      end
      default: begin
        waddr = clr;
        wdata = '{parent: clr, sz: SW'(1)};
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (uw.mem_we) begin
      mem[waddr] <= wdata;
    end
    rd <= mem[cur];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_count <= '0;
    end else if (write_enable) begin
      vertex_count <= write_data;
    end
  end

  // control state and the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      best          <= SW'(1);
      bad           <= 1'b0;
      clr           <= '0;
      result_valid  <= 1'b0;
    end else begin
      // emit only when the old result is gone or leaving this cycle
      if (uw.ld == LD_EMIT && !jump) begin
        result_valid <= 1'b1;
      end else if (result_valid && result_ready) begin
        result_valid <= 1'b0;
      end
      unique case (uw.ld)
        LD_START: begin
          if (oor) begin
            bad <= 1'b1;
          end
        end
        LD_BEST: begin
          if (merged > best) begin
            best <= merged;
          end
        end
        LD_CLEAR: begin
          clr <= clr + 1'b1;
          if (!jump) begin
            // last entry written: graph state back to empty
            best <= SW'(1);
            bad  <= 1'b0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    unique case (uw.ld)
      LD_TAKE: begin
        if (fire) begin
          cmd_r <= command;
          a_r   <= endpoint_a;
          b_r   <= endpoint_b;
        end
      end
      LD_START: begin
        cur <= a_r;
      end
      LD_FIND_A: begin
        if (jump) begin
          cur <= rd.parent;
        end else begin
          ra  <= cur;
          sza <= rd.sz;
          cur <= b_r;
        end
      end
      LD_FIND_B: begin
        if (jump) begin
          cur <= rd.parent;
        end else begin
          rb  <= cur;
          szb <= rd.sz;
        end
      end
      LD_EMIT: begin
        if (!jump) begin
          largest_size  <= best;
          bad_edge_seen <= bad;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

// File: rtl/core/lcc_seq.sv
// Microcode sequencer: step counter, control ROM and conditional jumps.
module lcc_seq import lcc_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  flags_t flags,
  output uword_t uw,
  output logic   jump
);

  pc_t pc;
  pc_t pc_next;

  function automatic uword_t mk(logic acc, logic we, wsel_e ws, ld_e ld, cond_e c, pc_t tgt);
    uword_t w;
    w.accept = acc;
    w.mem_we = we;
    w.wsel   = ws;
    w.ld     = ld;
    w.cond   = c;
    w.target = tgt;
    return w;
  endfunction

  function automatic uword_t ucode_rom(pc_t p);
    uword_t w;
    unique case (p)
      ST_WAIT:  w = mk(1'b1, 1'b0, W_LINK,  LD_TAKE,   C_NOT_FIRE, ST_WAIT);
      ST_DISP:  w = mk(1'b0, 1'b0, W_LINK,  LD_NONE,   C_CMD,      ST_EMIT);
      ST_RANGE: w = mk(1'b0, 1'b0, W_LINK,  LD_START,  C_OOR,      ST_WAIT);
      ST_RD_A:  w = mk(1'b0, 1'b0, W_LINK,  LD_NONE,   C_NEVER,    ST_WAIT);
      ST_CHK_A: w = mk(1'b0, 1'b0, W_LINK,  LD_FIND_A, C_NOT_ROOT, ST_RD_A);
      ST_RD_B:  w = mk(1'b0, 1'b0, W_LINK,  LD_NONE,   C_NEVER,    ST_WAIT);
      ST_CHK_B: w = mk(1'b0, 1'b0, W_LINK,  LD_FIND_B, C_NOT_ROOT, ST_RD_B);
      ST_LINK:  w = mk(1'b0, 1'b1, W_LINK,  LD_NONE,   C_SAME,     ST_WAIT);
      ST_GROW:  w = mk(1'b0, 1'b1, W_GROW,  LD_BEST,   C_ALWAYS,   ST_WAIT);
      ST_EMIT:  w = mk(1'b0, 1'b0, W_LINK,  LD_EMIT,   C_OUT_BUSY, ST_EMIT);
      ST_CLEAR: w = mk(1'b0, 1'b1, W_CLEAR, LD_CLEAR,  C_CLR_MORE, ST_CLEAR);
      ST_BACK:  w = mk(1'b0, 1'b0, W_LINK,  LD_NONE,   C_ALWAYS,   ST_WAIT);
      default:  w = mk(1'b0, 1'b0, W_LINK,  LD_NONE,   C_ALWAYS,   ST_WAIT);
    endcase
    return w;
  endfunction

  assign uw = ucode_rom(pc);

  always_comb begin
    unique case (uw.cond)
      C_NEVER:    jump = 1'b0;
      C_ALWAYS:   jump = 1'b1;
      C_NOT_FIRE: jump = !flags.fire;
      C_CMD:      jump = flags.cmd;
      C_OOR:      jump = flags.oor;
      C_NOT_ROOT: jump = flags.not_root;
      C_SAME:     jump = flags.same;
      C_OUT_BUSY: jump = flags.out_busy;
      C_CLR_MORE: jump = flags.clr_more;
      default:    jump = 1'b1;
    endcase
  end

  assign pc_next = jump ? uw.target : pc + 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= ST_CLEAR;  // start with a clearing pass
    end else begin
      pc <= pc_next;
    end
  end

endmodule

// File: rtl/core/lcc_checker.sv
// Port-level checker for the component-size unit, bound to the top level.
`include "assert_macros.svh"

module lcc_checker (
  input logic        clk,
  input logic        rst,
  input logic        item_valid,
  input logic        item_ready,
  input logic        command,
  input logic        result_valid,
  input logic        result_ready,
  input logic [10:0] largest_size,
  input logic        bad_edge_seen
);

  `LCC_ASSERT_NEXT(a_hold, result_valid && !result_ready, result_valid && $stable(largest_size) && $stable(bad_edge_seen), "stalled result changed")
  `LCC_ASSERT(a_range, result_valid |-> (largest_size != 11'd0) && (largest_size <= 11'd1024), "largest_size out of range")
  `LCC_ASSERT_NEXT(a_end_busy, item_valid && item_ready && command, !item_ready, "ready right after end item")
  `LCC_ASSERT(a_new_result, $rose(result_valid) |-> !$past(item_ready), "result appeared while taking items")

endmodule

bind largest_connected_component_unit lcc_checker u_lcc_checker (.*);

// File: bench/lcc_component_checker.sv
// Command codes and the scoreboard that predicts and checks component-size reports.
`timescale 1ns / 100ps

package lcc_bench_pkg;
  typedef enum logic {
    OP_ADD_EDGE,
    OP_END_GRAPH
  } graph_op_e;
endpackage

module lcc_component_checker
  import lcc_pkg::*;
  import lcc_bench_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        write_enable,
  input  logic [9:0]  write_data,
  input  logic        item_valid,
  input  logic        item_ready,
  input  logic        command,
  input  logic [9:0]  endpoint_a,
  input  logic [9:0]  endpoint_b,
  input  logic        result_valid,
  input  logic        result_ready,
  input  logic [10:0] largest_size,
  input  logic        bad_edge_seen,
  output int          mismatch_count,
  output int          results_owed
);

  typedef struct packed {
    cnt_t size;
    logic bad;
  } component_report_t;

  vtx_t              parent_tbl [MAX_V];
  cnt_t              size_tbl   [MAX_V];
  cnt_t              best_size;
  logic              bad_seen;
  vtx_t              vertex_limit;
  component_report_t report_q [$];
  int                errors = 0;

  function automatic void clear_graph();
    int v;
    for (v = 0; v < MAX_V; v++) begin
      parent_tbl[v] = vtx_t'(v);
      size_tbl[v]   = cnt_t'(1);
    end
    best_size = cnt_t'(1);
    bad_seen  = 1'b0;
  endfunction

  function automatic vtx_t find_root(vtx_t v);
    vtx_t cur;
    int   hops;
    cur  = v;
    hops = 0;
    while (parent_tbl[cur] != cur && hops < MAX_V) begin
      cur = parent_tbl[cur];
      hops++;
    end
    return cur;
  endfunction

  // union by size; ties keep the first endpoint's root on top
  function automatic void add_edge(vtx_t a, vtx_t b);
    vtx_t ra, rb, major, minor;
    cnt_t merged;
    if (a > vertex_limit || b > vertex_limit) begin
      bad_seen = 1'b1;
      return;
    end
    ra = find_root(a);
    rb = find_root(b);
    if (ra == rb) return;
    if (size_tbl[ra] >= size_tbl[rb]) begin
      major = ra;
      minor = rb;
    end else begin
      major = rb;
      minor = ra;
    end
    merged            = size_tbl[major] + size_tbl[minor];
    parent_tbl[minor] = major;
    size_tbl[major]   = merged;
    if (merged > best_size) best_size = merged;
  endfunction

  always @(posedge clk) begin
    component_report_t want;
    if (rst) begin
      vertex_limit = '0;
      clear_graph();
      report_q.delete();
      errors = 0;
    end else begin
      if (write_enable) vertex_limit = write_data;
      if (item_valid && item_ready) begin
        if (command == OP_END_GRAPH) begin
          report_q.push_back('{size: best_size, bad: bad_seen});
          clear_graph();
        end else begin
          add_edge(endpoint_a, endpoint_b);
        end
      end
      if (result_valid && result_ready) begin
        if (report_q.size() == 0) begin
          $error("unexpected report: largest_size %0d bad_edge_seen %0b",
                 largest_size, bad_edge_seen);
          errors++;
        end else begin
          want = report_q.pop_front();
          if (largest_size !== want.size) begin
            $error("largest_size: expected %0d, got %0d", want.size, largest_size);
            errors++;
          end
          if (bad_edge_seen !== want.bad) begin
            $error("bad_edge_seen: expected %0b, got %0b", want.bad, bad_edge_seen);
            errors++;
          end
        end
      end
    end
    mismatch_count <= errors;
    results_owed   <= report_q.size();
  end

endmodule

// File: bench/tb_largest_connected_component_unit.sv
// Stimulus, clock, reset and verdict for the largest-component unit.
`timescale 1ns / 100ps

module tb_largest_connected_component_unit;
  import lcc_pkg::*;
  import lcc_bench_pkg::*;

  localparam int RANDOM_ITEMS = 900;
  // wait for the deepest edge walk to finish, with a little margin on top
  localparam int EDGE_SETTLE  = 64;
  // end of graph starts a 1024-entry clear of the store
  localparam int CLEAR_WAIT   = 1100;
  // longest quiet stretch in a good run is a clear plus a stall
  localparam int STALL_LIMIT  = 5000;

  logic        clk          = 1'b0;
  logic        rst          = 1'b1;
  logic        write_enable = 1'b0;
  logic [9:0]  write_data   = '0;
  logic        item_valid   = 1'b0;
  logic        command      = 1'b0;
  logic [9:0]  endpoint_a   = '0;
  logic [9:0]  endpoint_b   = '0;
  logic        result_ready = 1'b0;
  logic        item_ready;
  logic        result_valid;
  logic [10:0] largest_size;
  logic        bad_edge_seen;

  // when set, neither side inserts bubbles
  logic        steady       = 1'b0;
  int          mismatch_count;
  int          results_owed;
  int          stalled_cycles = 0;

  always #1 clk = ~clk;

  largest_connected_component_unit i_dut (
    .clk          (clk),
    .rst          (rst),
    .write_enable (write_enable),
    .write_data   (write_data),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .command      (command),
    .endpoint_a   (endpoint_a),
    .endpoint_b   (endpoint_b),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .largest_size (largest_size),
    .bad_edge_seen(bad_edge_seen)
  );

  lcc_component_checker i_checker (
    .clk           (clk),
    .rst           (rst),
    .write_enable  (write_enable),
    .write_data    (write_data),
    .item_valid    (item_valid),
    .item_ready    (item_ready),
    .command       (command),
    .endpoint_a    (endpoint_a),
    .endpoint_b    (endpoint_b),
    .result_valid  (result_valid),
    .result_ready  (result_ready),
    .largest_size  (largest_size),
    .bad_edge_seen (bad_edge_seen),
    .mismatch_count(mismatch_count),
    .results_owed  (results_owed)
  );

  // Report side: back-pressure ~20% of cycles unless in the steady stretch.
  always @(posedge clk)
    result_ready <= !rst && (steady || $urandom_range(0, 99) >= 20);

  // Watchdog: any handshake on either channel counts as progress.
  always @(posedge clk) begin
    if (rst || (item_valid && item_ready) || (result_valid && result_ready))
      stalled_cycles <= 0;
    else
      stalled_cycles <= stalled_cycles + 1;
    if (stalled_cycles >= STALL_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Present one item, with random bubbles ahead of it; returns on the accepting edge.
  // Valid is only dropped inside a bubble, so back-to-back items keep it high.
  task automatic push_item(input graph_op_e op, input vtx_t a, input vtx_t b);
    while (!steady && $urandom_range(0, 99) < 20) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item_valid <= 1'b1;
    command    <= op;
    endpoint_a <= a;
    endpoint_b <= b;
    @(posedge clk);
    while (!item_ready) @(posedge clk);
  endtask

  task automatic write_vertex_count(input int unsigned value);
    write_enable <= 1'b1;
    write_data   <= value[9:0];
    @(posedge clk);
    write_enable <= 1'b0;
  endtask

  // Mid-graph register change: edges give no report, so wait out the worst
  // edge latency before touching the limit.
  task automatic retune_mid_graph(input int unsigned value);
    item_valid <= 1'b0;
    repeat (EDGE_SETTLE) @(posedge clk);
    write_vertex_count(value);
  endtask

  // After an end item: wait for its report, then let the store clear finish.
  task automatic finish_graph();
    item_valid <= 1'b0;
    do @(posedge clk); while (results_owed != 0);
    repeat (CLEAR_WAIT) @(posedge clk);
  endtask

  // Endpoints come from a 64-vertex window so large graphs still merge deeply.
  function automatic void pick_window(input int unsigned vc,
                                      output int unsigned lo, output int unsigned hi);
    if (vc > 63) begin
      lo = $urandom_range(0, vc - 63);
      hi = lo + 63;
    end else begin
      lo = 0;
      hi = vc;
    end
  endfunction

  function automatic int unsigned random_vertex_count();
    case ($urandom_range(0, 9))
      0:       return 1023;
      1:       return $urandom_range(0, 3);
      default: return $urandom_range(4, 48);
    endcase
  endfunction

  initial begin
    int unsigned vc, lo, hi;
    int          n_edges, retune_at, graph_no, items_done, i;

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // --- directed ---
    // empty graph at the reset limit: only vertex 0, size one
    push_item(OP_END_GRAPH, 10'd0, 10'd0);
    finish_graph();

    // limit 0: self loop on vertex 0 is legal, anything naming vertex 1 is flagged
    write_vertex_count(0);
    push_item(OP_ADD_EDGE, 10'd0, 10'd0);
    push_item(OP_ADD_EDGE, 10'd0, 10'd1);
    push_item(OP_END_GRAPH, 10'd1023, 10'd0);
    finish_graph();

    // full range: top vertex, self loop, an edge inside one component, alternating bit patterns
    write_vertex_count(1023);
    push_item(OP_ADD_EDGE, 10'd0, 10'd1023);
    push_item(OP_ADD_EDGE, 10'd1023, 10'd512);
    push_item(OP_ADD_EDGE, 10'd1023, 10'd1023);
    push_item(OP_ADD_EDGE, 10'd0, 10'd512);
    push_item(OP_ADD_EDGE, 10'h155, 10'h2AA);
    push_item(OP_ADD_EDGE, 10'h2AA, 10'd0);
    push_item(OP_END_GRAPH, 10'd1023, 10'd1023);
    finish_graph();

    // small limit with bad edges, then the limit widened mid-graph
    write_vertex_count(5);
    push_item(OP_ADD_EDGE, 10'd1, 10'd2);
    push_item(OP_ADD_EDGE, 10'd3, 10'd4);
    push_item(OP_ADD_EDGE, 10'd2, 10'd4);
    push_item(OP_ADD_EDGE, 10'd5, 10'd6);
    push_item(OP_ADD_EDGE, 10'd1023, 10'd0);
    push_item(OP_ADD_EDGE, 10'd5, 10'd5);
    retune_mid_graph(10);
    push_item(OP_ADD_EDGE, 10'd6, 10'd7);
    push_item(OP_ADD_EDGE, 10'd7, 10'd2);
    push_item(OP_ADD_EDGE, 10'd10, 10'd9);
    push_item(OP_END_GRAPH, 10'd0, 10'd0);
    finish_graph();

    // --- random graphs ---
    // Mostly in-window edges so trees grow; ~10% raw 10-bit noise (often out of
    // range). Every item counts toward the item budget.
    graph_no   = 0;
    items_done = 0;
    while (items_done < RANDOM_ITEMS) begin
      graph_no++;
      steady <= (graph_no >= 12 && graph_no < 16);
      vc = random_vertex_count();
      write_vertex_count(vc);
      pick_window(vc, lo, hi);
      n_edges   = $urandom_range(1, 30);
      retune_at = (n_edges > 1 && $urandom_range(0, 7) == 0) ?
                  $urandom_range(1, n_edges - 1) : n_edges;
      for (i = 0; i < n_edges; i++) begin
        if (i == retune_at) begin
          vc = random_vertex_count();
          retune_mid_graph(vc);
          pick_window(vc, lo, hi);
        end
        if ($urandom_range(0, 9) == 0) begin
          push_item(OP_ADD_EDGE, vtx_t'($urandom), vtx_t'($urandom));
        end else begin
          push_item(OP_ADD_EDGE, vtx_t'($urandom_range(lo, hi)),
                    vtx_t'($urandom_range(lo, hi)));
        end
        items_done++;
      end
      // endpoint fields are don't-care on the end item
      push_item(OP_END_GRAPH, vtx_t'($urandom), vtx_t'($urandom));
      items_done++;
      finish_graph();
    end

    if (mismatch_count == 0 && results_owed == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule
